// File: sv/ptrr_pkg.sv
// ----------------------------------------------------------------------------
// ptrr_pkg: process table round-robin core shared definitions
// Slot status codes, command codes, sequencer states and field widths.
// ----------------------------------------------------------------------------
package ptrr_pkg;

	// default table depth
	localparam int SLOTS_DEF = 64;

	// fixed field widths
	localparam int OP_W    = 3;
	localparam int IDX_IN_W = 6;
	localparam int PID_W   = 32;
	localparam int EXIT_W  = 32;
	localparam int CHILD_W = 6;

	// child count saturation point
	localparam logic [CHILD_W-1:0] CHILD_MAX = CHILD_W'(63);

	// first pid handed out after reset
	localparam logic [PID_W-1:0] PID_FIRST = PID_W'(1);

	// slot status
	typedef enum logic [2:0] {
		STAT_UNUSED  = 3'd0,
		STAT_UNINIT  = 3'd1,
		STAT_RUNNING = 3'd2,
		STAT_READY   = 3'd3,
		STAT_BLOCKED = 3'd4,
		STAT_ZOMBIE  = 3'd5
	} status_t;

	// internal command, op codes plus schedule
	typedef enum logic [3:0] {
		CMD_ALLOC  = 4'd0,
		CMD_FREE   = 4'd1,
		CMD_READY  = 4'd2,
		CMD_YIELD  = 4'd3,
		CMD_BLOCK  = 4'd4,
		CMD_FORK   = 4'd5,
		CMD_ZOMBIE = 4'd6,
		CMD_FIND   = 4'd7,
		CMD_SCHED  = 4'd8
	} cmd_t;

	// sequencer states
	typedef enum logic [2:0] {
		SEQ_IDLE = 3'd0,
		SEQ_RD   = 3'd1,
		SEQ_EV   = 3'd2,
		SEQ_SCAN = 3'd3,
		SEQ_DONE = 3'd4
	} seq_state_t;

endpackage

// File: sv/ptrr_in_if.sv
// ----------------------------------------------------------------------------
// ptrr_in_if: command channel
// Valid/ready channel carrying one table operation per item.
// ----------------------------------------------------------------------------
interface ptrr_in_if;
	logic                                 valid;
	logic                                 ready;
	logic [ptrr_pkg::OP_W-1:0]            op;
	logic                                 do_schedule;
	logic [ptrr_pkg::IDX_IN_W-1:0]        slot_index;
	logic signed [ptrr_pkg::EXIT_W-1:0]   exit_value_in;

	modport source (output valid, op, do_schedule, slot_index, exit_value_in, input ready);
	modport sink (input valid, op, do_schedule, slot_index, exit_value_in, output ready);
endinterface

// File: sv/ptrr_out_if.sv
// ----------------------------------------------------------------------------
// ptrr_out_if: result channel
// Valid/ready channel carrying one result item per operation.
// ----------------------------------------------------------------------------
interface ptrr_out_if;
	logic                                 valid;
	logic                                 ready;
	logic                                 found;
	logic [ptrr_pkg::IDX_IN_W-1:0]        slot_out;
	logic [ptrr_pkg::PID_W-1:0]           pid_out;
	logic signed [ptrr_pkg::EXIT_W-1:0]   exit_value_out;
	logic [ptrr_pkg::IDX_IN_W-1:0]        current_out;
	logic                                 notify_parent;
	logic [ptrr_pkg::IDX_IN_W-1:0]        parent_out;

	modport source (output valid, found, slot_out, pid_out, exit_value_out, current_out,
		notify_parent, parent_out, input ready);
	modport sink (input valid, found, slot_out, pid_out, exit_value_out, current_out,
		notify_parent, parent_out, output ready);
endinterface

// File: sv/process_table_round_robin_core.sv
// ----------------------------------------------------------------------------
// process_table_round_robin_core: hardware process table with round-robin pick
// Slot table in a memory with one write and one read port, walked by a small sequencer.
// ----------------------------------------------------------------------------
// The table lives in one memory of SLOTS rows with one write and one registered
// read per cycle, and a sequencer visits it one slot per cycle. free, mark_ready,
// yield and block read and write back one row; fork_link reads and writes two
// (target row, then current row). alloc, find_zombie and schedule walk the
// table and stop at the first hit, make_zombie always walks it all. A target
// not below SLOTS gives its empty result without touching the table. A per-row
// valid bit, cleared by reset, stands in for the reset contents, so there is no
// clearing pass. A new item is taken while the last result still waits in the
// output register.
module process_table_round_robin_core #(
	parameter int SLOTS = ptrr_pkg::SLOTS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	ptrr_in_if.sink          in_ch,
	ptrr_out_if.source       out_ch
);

	localparam int IDX_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int PID_W   = ptrr_pkg::PID_W;
	localparam int EXIT_W  = ptrr_pkg::EXIT_W;
	localparam int CHILD_W = ptrr_pkg::CHILD_W;
	localparam int OUT_W   = ptrr_pkg::IDX_IN_W;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

	typedef struct packed {
		ptrr_pkg::status_t   status;
		logic                pvalid;
		logic [IDX_W-1:0]    parent;
		logic [PID_W-1:0]    pid;
		logic [CHILD_W-1:0]  ccount;
		logic [EXIT_W-1:0]   exitv;
	} row_t;

	// table storage
	row_t                    row_mem_q [SLOTS];
	row_t                    rd_row_q;
	logic [SLOTS-1:0]        row_valid_q;

	// sequencer and item registers
	ptrr_pkg::seq_state_t    state_q, state_d;
	ptrr_pkg::cmd_t          cmd_q;
	logic [IDX_W-1:0]        tgt_q;
	logic [EXIT_W-1:0]       xin_q;
	logic [IDX_W-1:0]        idx_q;
	logic [IDX_W-1:0]        cnt_q;
	logic                    phase_q;
	logic [IDX_W-1:0]        cur_q;
	logic [PID_W-1:0]        pidc_q;

	// result being built
	logic                    res_found_q;
	logic [IDX_W-1:0]        res_slot_q;
	logic [PID_W-1:0]        res_pid_q;
	logic [EXIT_W-1:0]       res_exit_q;
	logic                    res_notify_q;
	logic [IDX_W-1:0]        res_parent_q;

	// output register
	logic                    out_valid_q;
	logic                    out_found_q;
	logic [OUT_W-1:0]        out_slot_q;
	logic [PID_W-1:0]        out_pid_q;
	logic [EXIT_W-1:0]       out_exit_q;
	logic [OUT_W-1:0]        out_cur_q;
	logic                    out_notify_q;
	logic [OUT_W-1:0]        out_parent_q;

	// combinational
	logic                    accept;
	logic                    tgt_ok;
	logic [IDX_W-1:0]        tgt_idx;
	ptrr_pkg::cmd_t          in_cmd;
	logic [IDX_W-1:0]        idx_nxt;
	logic [IDX_W-1:0]        cur_nxt;
	logic [IDX_W-1:0]        rd_addr;
	row_t                    row;
	row_t                    rst_row;
	logic                    hit;
	logic                    last;
	logic                    out_free;
	logic                    wr_en;
	row_t                    wr_row;

	assign accept   = in_ch.valid && in_ch.ready;
	assign out_free = !out_valid_q || out_ch.ready;
	assign in_ch.ready = (state_q == ptrr_pkg::SEQ_IDLE);

	// decode incoming item
	assign in_cmd  = in_ch.do_schedule ? ptrr_pkg::CMD_SCHED : ptrr_pkg::cmd_t'({1'b0, in_ch.op});
	assign tgt_ok  = ({26'd0, in_ch.slot_index} < 32'(SLOTS));
	assign tgt_idx = IDX_W'(in_ch.slot_index);
	assign cur_nxt = (cur_q == LAST_IDX) ? '0 : cur_q + 1'b1;
	assign idx_nxt = (idx_q == LAST_IDX) ? '0 : idx_q + 1'b1;
	assign last    = (cnt_q == LAST_IDX);

	// row as seen at idx_q, reset contents where never written
	always_comb begin
		rst_row        = '0;
		rst_row.status = (idx_q == '0) ? ptrr_pkg::STAT_RUNNING : ptrr_pkg::STAT_UNUSED;
		row            = row_valid_q[idx_q] ? rd_row_q : rst_row;
	end

	// scan hit for the current slot
	always_comb begin
		unique case (cmd_q)
			ptrr_pkg::CMD_ALLOC: hit = (row.status == ptrr_pkg::STAT_UNUSED);
			ptrr_pkg::CMD_SCHED: hit = (row.status == ptrr_pkg::STAT_READY);
			ptrr_pkg::CMD_FIND:  hit = row.pvalid && (row.parent == tgt_q) &&
				(row.status == ptrr_pkg::STAT_ZOMBIE);
			default:             hit = 1'b0;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ptrr_pkg::SEQ_IDLE: begin
				if (accept) begin
					unique case (in_cmd)
						ptrr_pkg::CMD_ALLOC, ptrr_pkg::CMD_SCHED,
						ptrr_pkg::CMD_YIELD, ptrr_pkg::CMD_BLOCK: state_d = ptrr_pkg::SEQ_RD;
						default: state_d = tgt_ok ? ptrr_pkg::SEQ_RD : ptrr_pkg::SEQ_DONE;
					endcase
				end
			end
			ptrr_pkg::SEQ_RD: begin
				priority if (cmd_q == ptrr_pkg::CMD_ALLOC || cmd_q == ptrr_pkg::CMD_SCHED ||
					cmd_q == ptrr_pkg::CMD_ZOMBIE || cmd_q == ptrr_pkg::CMD_FIND)
					state_d = ptrr_pkg::SEQ_SCAN;
				else
					state_d = ptrr_pkg::SEQ_EV;
			end
			ptrr_pkg::SEQ_EV: begin
				if (cmd_q == ptrr_pkg::CMD_FORK && !phase_q) state_d = ptrr_pkg::SEQ_RD;
				else state_d = ptrr_pkg::SEQ_DONE;
			end
			ptrr_pkg::SEQ_SCAN: begin
				if (hit || last) state_d = ptrr_pkg::SEQ_DONE;
			end
			ptrr_pkg::SEQ_DONE: begin
				if (out_free) state_d = ptrr_pkg::SEQ_IDLE;
			end
			default: state_d = ptrr_pkg::SEQ_IDLE;
		endcase
	end

	// table write and read address
	always_comb begin
		wr_en   = 1'b0;
		wr_row  = row;
		rd_addr = idx_q;
		unique case (state_q)
			ptrr_pkg::SEQ_EV: begin
				wr_en = 1'b1;
				unique case (cmd_q)
					ptrr_pkg::CMD_FREE:  wr_row.status = ptrr_pkg::STAT_UNUSED;
					ptrr_pkg::CMD_READY,
					ptrr_pkg::CMD_YIELD: wr_row.status = ptrr_pkg::STAT_READY;
					ptrr_pkg::CMD_BLOCK: wr_row.status = ptrr_pkg::STAT_BLOCKED;
					ptrr_pkg::CMD_FORK: begin
						if (!phase_q) begin
							wr_row.pvalid = 1'b1;
							wr_row.parent = cur_q;
						end else if (row.ccount < ptrr_pkg::CHILD_MAX) begin
							wr_row.ccount = row.ccount + 1'b1;
						end
					end
					default: wr_en = 1'b0;
				endcase
			end
			ptrr_pkg::SEQ_SCAN: begin
				rd_addr = idx_nxt;
				unique case (cmd_q)
					ptrr_pkg::CMD_ALLOC: begin
						wr_en         = hit;
						wr_row.status = ptrr_pkg::STAT_UNINIT;
						wr_row.pvalid = 1'b0;
						wr_row.parent = '0;
						wr_row.pid    = pidc_q;
						wr_row.ccount = '0;
					end
					ptrr_pkg::CMD_SCHED: begin
						wr_en         = hit;
						wr_row.status = ptrr_pkg::STAT_RUNNING;
					end
					ptrr_pkg::CMD_ZOMBIE: begin
						wr_en = 1'b1;
						if (idx_q == tgt_q) begin
							wr_row.status = ptrr_pkg::STAT_ZOMBIE;
							wr_row.exitv  = xin_q;
						end
						if (row.pvalid && row.parent == tgt_q) wr_row.pvalid = 1'b0;
					end
					default: wr_en = 1'b0;
				endcase
			end
			default: ;
		endcase
	end

	// table memory
	always_ff @(posedge clk) begin
		if (wr_en) row_mem_q[idx_q] <= wr_row;
		rd_row_q <= row_mem_q[rd_addr];
	end

	// row valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
		end else if (wr_en) begin
			row_valid_q[idx_q] <= 1'b1;
		end
	end

	// sequencer control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ptrr_pkg::SEQ_IDLE;
			cur_q   <= '0;
			pidc_q  <= ptrr_pkg::PID_FIRST;
			cmd_q   <= ptrr_pkg::CMD_ALLOC;
			idx_q   <= '0;
			cnt_q   <= '0;
			phase_q <= 1'b0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				ptrr_pkg::SEQ_IDLE: begin
					if (accept) begin
						cmd_q   <= in_cmd;
						cnt_q   <= '0;
						phase_q <= 1'b0;
						unique case (in_cmd)
							ptrr_pkg::CMD_SCHED: idx_q <= cur_nxt;
							ptrr_pkg::CMD_YIELD,
							ptrr_pkg::CMD_BLOCK: idx_q <= cur_q;
							ptrr_pkg::CMD_FREE, ptrr_pkg::CMD_READY,
							ptrr_pkg::CMD_FORK:  idx_q <= tgt_idx;
							default:             idx_q <= '0;
						endcase
					end
				end
				ptrr_pkg::SEQ_EV: begin
					if (cmd_q == ptrr_pkg::CMD_FORK) begin
						phase_q <= 1'b1;
						idx_q   <= cur_q;
					end
				end
				ptrr_pkg::SEQ_SCAN: begin
					if (hit && cmd_q == ptrr_pkg::CMD_ALLOC) pidc_q <= pidc_q + 1'b1;
					if (hit && cmd_q == ptrr_pkg::CMD_SCHED) cur_q <= idx_q;
					if (!hit && !last) begin
						idx_q <= idx_nxt;
						cnt_q <= cnt_q + 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// item payload and result build-up
	always_ff @(posedge clk) begin
		if (accept) begin
			tgt_q        <= tgt_idx;
			xin_q        <= in_ch.exit_value_in;
			res_found_q  <= 1'b0;
			res_slot_q   <= '0;
			res_pid_q    <= '0;
			res_exit_q   <= '0;
			res_notify_q <= 1'b0;
			res_parent_q <= '0;
		end else if (state_q == ptrr_pkg::SEQ_SCAN) begin
			if (hit) begin
				res_found_q <= 1'b1;
				res_slot_q  <= idx_q;
				res_pid_q   <= (cmd_q == ptrr_pkg::CMD_ALLOC) ? pidc_q : row.pid;
				if (cmd_q == ptrr_pkg::CMD_FIND) res_exit_q <= row.exitv;
			end
			if (cmd_q == ptrr_pkg::CMD_ZOMBIE && idx_q == tgt_q &&
				row.pvalid && row.parent != tgt_q) begin
				res_notify_q <= 1'b1;
				res_parent_q <= row.parent;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ptrr_pkg::SEQ_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ptrr_pkg::SEQ_DONE && out_free) begin
			out_found_q  <= res_found_q;
			out_slot_q   <= OUT_W'(res_slot_q);
			out_pid_q    <= res_pid_q;
			out_exit_q   <= res_exit_q;
			out_cur_q    <= OUT_W'(cur_q);
			out_notify_q <= res_notify_q;
			out_parent_q <= OUT_W'(res_parent_q);
		end
	end

	assign out_ch.valid          = out_valid_q;
	assign out_ch.found          = out_found_q;
	assign out_ch.slot_out       = out_slot_q;
	assign out_ch.pid_out        = out_pid_q;
	assign out_ch.exit_value_out = out_exit_q;
	assign out_ch.current_out    = out_cur_q;
	assign out_ch.notify_parent  = out_notify_q;
	assign out_ch.parent_out     = out_parent_q;

endmodule

// File: tb/process_table_round_robin_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// process_table_round_robin_core_tb: self-checking bench for the process table
// Drives table operations and schedules through the command channel in random
// bursts while the result channel stalls on its own pattern. A behavioral
// copy of the slot table predicts every result item. A short directed table
// covers reset, extremes and the no-hit cases, then lifecycle sequences,
// an alloc-heavy fill of the table and free random items follow.
// ----------------------------------------------------------------------------
module process_table_round_robin_core_tb;

	localparam int CLK_PERIOD  = 2;
	localparam int N_SLOTS     = ptrr_pkg::SLOTS_DEF;
	localparam int CYCLE_LIMIT = 500000;

	// one command item as driven
	typedef struct packed {
		logic [ptrr_pkg::OP_W-1:0]            op;
		logic                                 do_schedule;
		logic [ptrr_pkg::IDX_IN_W-1:0]        slot_index;
		logic signed [ptrr_pkg::EXIT_W-1:0]   exit_value;
	} table_cmd_t;

	// one result item as expected
	typedef struct packed {
		logic                                 found;
		logic [ptrr_pkg::IDX_IN_W-1:0]        slot;
		logic [ptrr_pkg::PID_W-1:0]           pid;
		logic signed [ptrr_pkg::EXIT_W-1:0]   exit_value;
		logic [ptrr_pkg::IDX_IN_W-1:0]        current;
		logic                                 notify;
		logic [ptrr_pkg::IDX_IN_W-1:0]        parent;
	} table_result_t;

	// directed row: command plus optional literal result
	typedef struct packed {
		table_cmd_t                 cmd;
		logic                       has_value;
		table_result_t              res;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n;

	ptrr_in_if  cmd_ch ();
	ptrr_out_if res_ch ();

	process_table_round_robin_core #(.SLOTS(N_SLOTS)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (cmd_ch),
		.out_ch (res_ch)
	);

	// shadow copy of the slot table
	ptrr_pkg::status_t                    slot_st [N_SLOTS];
	logic                                 par_v   [N_SLOTS];
	logic [ptrr_pkg::IDX_IN_W-1:0]        par_s   [N_SLOTS];
	logic [ptrr_pkg::PID_W-1:0]           pid_tab [N_SLOTS];
	logic [ptrr_pkg::CHILD_W-1:0]         kids    [N_SLOTS];
	logic signed [ptrr_pkg::EXIT_W-1:0]   xv_tab  [N_SLOTS];
	logic [ptrr_pkg::IDX_IN_W-1:0]        cur_slot;
	logic [ptrr_pkg::PID_W-1:0]           pid_ctr;

	table_result_t pending_results [$];
	table_result_t last_result;
	dir_row_t      dir_rows [$];
	int            err_count = 0;
	int            cycle_cnt = 0;
	int            burst_left = 0;
	int            life_slot = 1;
	int            life_parent = 0;

	always #(CLK_PERIOD / 2) clk = ~clk;

	// table state after reset
	task automatic reset_table();
		for (int i = 0; i < N_SLOTS; i++) begin
			slot_st[i] = ptrr_pkg::STAT_UNUSED;
			par_v[i]   = 1'b0;
			par_s[i]   = '0;
			pid_tab[i] = '0;
			kids[i]    = '0;
			xv_tab[i]  = '0;
		end
		slot_st[0] = ptrr_pkg::STAT_RUNNING;
		cur_slot   = '0;
		pid_ctr    = ptrr_pkg::PID_FIRST;
	endtask

	// apply one command to the shadow table and return its result
	function automatic table_result_t apply_table_op(table_cmd_t c);
		table_result_t r;
		int cur;
		int t;
		int n;
		bit tgt_ok;
		r = '0;
		cur = int'(cur_slot) % N_SLOTS;
		t = int'(c.slot_index);
		tgt_ok = (t < N_SLOTS);
		if (c.do_schedule) begin
			// round-robin pick, current slot last
			for (int i = 0; i < N_SLOTS; i++) begin
				n = (cur + 1 + i) % N_SLOTS;
				if (slot_st[n] == ptrr_pkg::STAT_READY) begin
					slot_st[n] = ptrr_pkg::STAT_RUNNING;
					cur_slot = ptrr_pkg::IDX_IN_W'(n);
					r.found = 1'b1;
					r.slot = ptrr_pkg::IDX_IN_W'(n);
					r.pid = pid_tab[n];
					break;
				end
			end
		end else begin
			unique case (ptrr_pkg::cmd_t'({1'b0, c.op}))
				ptrr_pkg::CMD_ALLOC: begin
					for (int i = 0; i < N_SLOTS; i++) begin
						if (slot_st[i] == ptrr_pkg::STAT_UNUSED) begin
							pid_tab[i] = pid_ctr;
							pid_ctr = pid_ctr + 1'b1;
							slot_st[i] = ptrr_pkg::STAT_UNINIT;
							par_v[i] = 1'b0;
							par_s[i] = '0;
							kids[i] = '0;
							r.found = 1'b1;
							r.slot = ptrr_pkg::IDX_IN_W'(i);
							r.pid = pid_tab[i];
							break;
						end
					end
				end
				ptrr_pkg::CMD_FREE: begin
					if (tgt_ok) slot_st[t] = ptrr_pkg::STAT_UNUSED;
				end
				ptrr_pkg::CMD_READY: begin
					if (tgt_ok) slot_st[t] = ptrr_pkg::STAT_READY;
				end
				ptrr_pkg::CMD_YIELD: begin
					slot_st[cur] = ptrr_pkg::STAT_READY;
				end
				ptrr_pkg::CMD_BLOCK: begin
					slot_st[cur] = ptrr_pkg::STAT_BLOCKED;
				end
				ptrr_pkg::CMD_FORK: begin
					if (tgt_ok) begin
						par_v[t] = 1'b1;
						par_s[t] = ptrr_pkg::IDX_IN_W'(cur);
						if (kids[cur] < ptrr_pkg::CHILD_MAX) kids[cur] = kids[cur] + 1'b1;
					end
				end
				ptrr_pkg::CMD_ZOMBIE: begin
					if (tgt_ok) begin
						slot_st[t] = ptrr_pkg::STAT_ZOMBIE;
						xv_tab[t] = c.exit_value;
						// orphan every child, the target itself included
						for (int i = 0; i < N_SLOTS; i++) begin
							if (par_v[i] && int'(par_s[i]) == t) par_v[i] = 1'b0;
						end
						if (par_v[t]) begin
							r.notify = 1'b1;
							r.parent = par_s[t];
						end
					end
				end
				default: begin
					// lowest zombie child of the target
					if (tgt_ok) begin
						for (int i = 0; i < N_SLOTS; i++) begin
							if (par_v[i] && int'(par_s[i]) == t &&
								slot_st[i] == ptrr_pkg::STAT_ZOMBIE) begin
								r.found = 1'b1;
								r.slot = ptrr_pkg::IDX_IN_W'(i);
								r.pid = pid_tab[i];
								r.exit_value = xv_tab[i];
								break;
							end
						end
					end
				end
			endcase
		end
		r.current = cur_slot;
		return r;
	endfunction

	function automatic table_cmd_t mk_cmd(ptrr_pkg::cmd_t k, int idx,
			logic [ptrr_pkg::EXIT_W-1:0] xv);
		table_cmd_t c;
		c.do_schedule = (k == ptrr_pkg::CMD_SCHED);
		c.op = (k == ptrr_pkg::CMD_SCHED) ? ptrr_pkg::OP_W'($urandom_range(0, 7)) :
			ptrr_pkg::OP_W'(k);
		c.slot_index = ptrr_pkg::IDX_IN_W'(idx);
		c.exit_value = xv;
		return c;
	endfunction

	function automatic table_result_t res_of(int f, int s, logic [ptrr_pkg::PID_W-1:0] p,
			logic [ptrr_pkg::EXIT_W-1:0] x, int cur, int nt, int pa);
		table_result_t r;
		r.found = 1'(f);
		r.slot = ptrr_pkg::IDX_IN_W'(s);
		r.pid = p;
		r.exit_value = x;
		r.current = ptrr_pkg::IDX_IN_W'(cur);
		r.notify = 1'(nt);
		r.parent = ptrr_pkg::IDX_IN_W'(pa);
		return r;
	endfunction

	function automatic dir_row_t row(ptrr_pkg::cmd_t k, int idx,
			logic [ptrr_pkg::EXIT_W-1:0] xv, int lit, table_result_t res);
		dir_row_t d;
		d.cmd = mk_cmd(k, idx, xv);
		d.has_value = 1'(lit);
		d.res = res;
		return d;
	endfunction

	// weighted random operation, targets mostly among the low slots unless wide is set
	function automatic table_cmd_t rand_cmd(bit wide);
		int r;
		int idx;
		ptrr_pkg::cmd_t k;
		r = $urandom_range(0, 99);
		if (r < 12) k = ptrr_pkg::CMD_ALLOC;
		else if (r < 20) k = ptrr_pkg::CMD_FREE;
		else if (r < 34) k = ptrr_pkg::CMD_READY;
		else if (r < 42) k = ptrr_pkg::CMD_YIELD;
		else if (r < 48) k = ptrr_pkg::CMD_BLOCK;
		else if (r < 60) k = ptrr_pkg::CMD_FORK;
		else if (r < 72) k = ptrr_pkg::CMD_ZOMBIE;
		else if (r < 84) k = ptrr_pkg::CMD_FIND;
		else k = ptrr_pkg::CMD_SCHED;
		idx = (wide || $urandom_range(0, 2) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 7);
		return mk_cmd(k, idx, $urandom);
	endfunction

	// drive one item in bursts, predict it on acceptance
	task automatic send_cmd(table_cmd_t c, bit lit, table_result_t lit_res);
		int gap;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 10);
			gap = $urandom_range(0, 6);
			repeat (gap) begin
				@(negedge clk);
				cmd_ch.valid <= 1'b0;
			end
		end
		burst_left--;
		@(negedge clk);
		cmd_ch.valid <= 1'b1;
		cmd_ch.op <= c.op;
		cmd_ch.do_schedule <= c.do_schedule;
		cmd_ch.slot_index <= c.slot_index;
		cmd_ch.exit_value_in <= c.exit_value;
		do @(posedge clk); while (cmd_ch.ready !== 1'b1);
		last_result = apply_table_op(c);
		pending_results.push_back(lit ? lit_res : last_result);
	endtask

	// hold the command channel until every result is back
	task automatic drain_results();
		@(negedge clk);
		cmd_ch.valid <= 1'b0;
		burst_left = 0;
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	// alloc, link, ready, run, yield, exit, reap, free with some noise
	task automatic run_lifecycle();
		ptrr_pkg::cmd_t steps [8];
		table_cmd_t c;
		int tgt;
		steps = '{ptrr_pkg::CMD_ALLOC, ptrr_pkg::CMD_FORK, ptrr_pkg::CMD_READY,
			ptrr_pkg::CMD_SCHED, ptrr_pkg::CMD_YIELD, ptrr_pkg::CMD_ZOMBIE,
			ptrr_pkg::CMD_FIND, ptrr_pkg::CMD_FREE};
		foreach (steps[k]) begin
			if ($urandom_range(0, 4) == 0) begin
				c = rand_cmd(1'b0);
			end else begin
				tgt = (steps[k] == ptrr_pkg::CMD_FIND) ? life_parent : life_slot;
				c = mk_cmd(steps[k], tgt, $urandom);
				if (steps[k] == ptrr_pkg::CMD_FORK) life_parent = int'(cur_slot);
			end
			send_cmd(c, 1'b0, '0);
			if (!c.do_schedule && ptrr_pkg::cmd_t'({1'b0, c.op}) == ptrr_pkg::CMD_ALLOC) begin
				life_slot = last_result.found ? int'(last_result.slot) :
					int'($urandom_range(0, 7));
			end
		end
	endtask

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
			err_count++;
		end
	endtask

	// result checker
	always @(posedge clk) begin
		table_result_t want;
		if (arst_n && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
			if (pending_results.size() == 0) begin
				$display("%0t: result item with none expected, expected none actual slot %0h",
					$time, res_ch.slot_out);
				err_count++;
			end else begin
				want = pending_results.pop_front();
				check_field("found", 32'(want.found), 32'(res_ch.found));
				check_field("slot_out", 32'(want.slot), 32'(res_ch.slot_out));
				check_field("pid_out", want.pid, res_ch.pid_out);
				check_field("exit_value_out", want.exit_value, res_ch.exit_value_out);
				check_field("current_out", 32'(want.current), 32'(res_ch.current_out));
				check_field("notify_parent", 32'(want.notify), 32'(res_ch.notify_parent));
				check_field("parent_out", 32'(want.parent), 32'(res_ch.parent_out));
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// receiver stalls: always ready, random, or a rotating pattern
	initial begin
		int mode_left;
		int mode;
		logic [7:0] pat;
		res_ch.ready = 1'b0;
		mode_left = 0;
		mode = 0;
		pat = 8'b1011_0110;
		forever begin
			@(negedge clk);
			if (mode_left == 0) begin
				mode = $urandom_range(0, 2);
				mode_left = $urandom_range(20, 120);
			end
			mode_left--;
			pat = {pat[6:0], pat[7]};
			unique case (mode)
				0: res_ch.ready <= 1'b1;
				1: res_ch.ready <= ($urandom_range(0, 3) != 0);
				default: res_ch.ready <= pat[0];
			endcase
		end
	end

	// stimulus
	initial begin
		arst_n = 1'b0;
		cmd_ch.valid = 1'b0;
		cmd_ch.op = '0;
		cmd_ch.do_schedule = 1'b0;
		cmd_ch.slot_index = '0;
		cmd_ch.exit_value_in = '0;
		reset_table();

		// directed rows, literal results where they are plain to see
		dir_rows = '{
			row(ptrr_pkg::CMD_SCHED, 0, 32'h0, 1, res_of(0, 0, 0, 0, 0, 0, 0)),
			row(ptrr_pkg::CMD_ALLOC, 0, 32'h0, 1, res_of(1, 1, 1, 0, 0, 0, 0)),
			row(ptrr_pkg::CMD_ALLOC, 63, 32'h0, 1, res_of(1, 2, 2, 0, 0, 0, 0)),
			row(ptrr_pkg::CMD_FORK, 1, 32'h0, 0, '0),
			row(ptrr_pkg::CMD_FORK, 2, 32'h0, 0, '0),
			row(ptrr_pkg::CMD_ZOMBIE, 2, 32'h7FFF_FFFF, 1, res_of(0, 0, 0, 0, 0, 1, 0)),
			row(ptrr_pkg::CMD_FIND, 0, 32'h0, 1, res_of(1, 2, 2, 32'h7FFF_FFFF, 0, 0, 0)),
			row(ptrr_pkg::CMD_ZOMBIE, 63, 32'h8000_0000, 1, res_of(0, 0, 0, 0, 0, 0, 0)),
			row(ptrr_pkg::CMD_FIND, 63, 32'h0, 1, res_of(0, 0, 0, 0, 0, 0, 0)),
			row(ptrr_pkg::CMD_READY, 1, 32'h0, 0, '0),
			row(ptrr_pkg::CMD_SCHED, 0, 32'h0, 0, '0),
			row(ptrr_pkg::CMD_YIELD, 63, 32'hFFFF_FFFF, 0, '0),
			row(ptrr_pkg::CMD_SCHED, 63, 32'h0, 0, '0),
			row(ptrr_pkg::CMD_BLOCK, 0, 32'h0, 0, '0),
			row(ptrr_pkg::CMD_READY, 63, 32'h0, 0, '0),
			row(ptrr_pkg::CMD_SCHED, 0, 32'h0, 0, '0),
			row(ptrr_pkg::CMD_SCHED, 0, 32'h0, 0, '0),
			row(ptrr_pkg::CMD_READY, 0, 32'h0, 0, '0),
			row(ptrr_pkg::CMD_SCHED, 0, 32'h0, 0, '0),
			row(ptrr_pkg::CMD_FORK, 0, 32'h0, 0, '0),
			row(ptrr_pkg::CMD_ZOMBIE, 0, 32'hFFFF_FFFF, 0, '0),
			row(ptrr_pkg::CMD_FIND, 0, 32'h0, 0, '0),
			row(ptrr_pkg::CMD_FREE, 2, 32'h0, 0, '0),
			row(ptrr_pkg::CMD_ALLOC, 0, 32'h0, 0, '0),
			row(ptrr_pkg::CMD_SCHED, 7, 32'h0, 0, '0)
		};

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (dir_rows[i]) send_cmd(dir_rows[i].cmd, dir_rows[i].has_value, dir_rows[i].res);
		drain_results();

		// well-formed lifecycles with random content
		repeat (25) run_lifecycle();
		drain_results();

		// alloc-heavy run to fill the table, with some random items mixed in
		repeat (70) begin
			if ($urandom_range(0, 9) == 0) send_cmd(rand_cmd(1'b1), 1'b0, '0);
			else send_cmd(mk_cmd(ptrr_pkg::CMD_ALLOC, $urandom_range(0, 63), $urandom),
				1'b0, '0);
		end

		// free random items over the whole table
		repeat (180) send_cmd(rand_cmd(1'($urandom_range(0, 1))), 1'b0, '0);

		@(negedge clk);
		cmd_ch.valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (2 * N_SLOTS + 10) @(posedge clk);

		if (err_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
